FILE: hdl/pbd_pkg.sv
package pbd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_STRIDE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_LEFT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_TOP   = 3'd4;

  localparam logic [13:0] STRIDE_SHORT_MAX = 14'd250;
  localparam logic [8:0]  REPEAT_BASE      = 9'h101;
  localparam logic [16:0] COLUMN_MAX       = 17'h1FFFF;

  typedef struct packed {
    logic        [13:0] row_stride;
    logic        [13:0] image_width;
    logic        [13:0] image_height;
    logic signed [15:0] origin_left;
    logic signed [15:0] origin_top;
  } cfg_t;

  typedef enum logic [5:0] {
    PH_COUNT     = 6'b000001,
    PH_COUNT_LOW = 6'b000010,
    PH_HEADER    = 6'b000100,
    PH_REPEAT    = 6'b001000,
    PH_LITERAL   = 6'b010000,
    PH_PAD       = 6'b100000
  } phase_t;

endpackage

FILE: hdl/pbd_if.sv
interface pbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface pbd_run_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  pixel_index;
  logic signed [15:0] pixel_column;
  logic signed [15:0] pixel_row;
  logic        [7:0]  run_length;
  logic               image_done;

  modport source (output valid, output pixel_index, output pixel_column, output pixel_row,
                  output run_length, output image_done, input ready);
  modport sink (input valid, input pixel_index, input pixel_column, input pixel_row,
                input run_length, input image_done, output ready);
endinterface

FILE: hdl/pbd_in_stage.sv
module pbd_in_stage (
  input  logic       clk,
  input  logic       rst,
  pbd_byte_if.sink   stream,
  input  logic       advance,
  output logic       valid,
  output logic [7:0] data
);

  assign stream.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (stream.ready) begin
      valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      data <= stream.stream_byte;
    end
  end

endmodule

FILE: hdl/pbd_decode.sv
module pbd_decode (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [7:0]   in_byte,
  output logic         advance,
  input  pbd_pkg::cfg_t cfg,
  pbd_run_if.source    runs
);
  import pbd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] row_bytes_left, row_bytes_left_next, rbl_dec;
  logic [7:0]  literal_left, literal_left_next, lit_dec;
  logic [7:0]  repeat_count, repeat_count_next;
  logic [7:0]  count_high, count_high_next;
  logic [16:0] column, column_next;
  logic [13:0] row, row_next, row_cur;
  logic        parity, parity_next, parity_cur;

  logic        emit, row_end, vis, done;
  logic [7:0]  len, rl;
  logic [17:0] col_sum;
  logic [16:0] room17;
  logic [13:0] room;
  logic [14:0] row_inc;

  logic               out_valid;
  logic        [7:0]  out_index;
  logic        [15:0] out_column;
  logic        [15:0] out_row;
  logic        [7:0]  out_len;
  logic               out_done;

  assign advance = in_valid && (!out_valid || runs.ready);

  assign rbl_dec = (row_bytes_left != 16'd0) ? row_bytes_left - 16'd1 : row_bytes_left;
  assign lit_dec = (literal_left != 8'd0) ? literal_left - 8'd1 : literal_left;

  always_comb begin
    phase_next          = phase;
    row_bytes_left_next = row_bytes_left;
    literal_left_next   = literal_left;
    repeat_count_next   = repeat_count;
    count_high_next     = count_high;
    column_next         = column;
    row_next            = row;
    parity_next         = parity;
    row_cur             = row;
    parity_cur          = parity;
    emit                = 1'b0;
    row_end             = 1'b0;
    len                 = 8'd0;
    done                = 1'b0;
    row_inc             = 15'd0;

    unique case (phase)
      PH_COUNT: begin
        if (cfg.row_stride == 14'd0 || cfg.image_height == 14'd0) begin
          row_next    = 14'd0;
          parity_next = 1'b0;
        end else begin
          if (row >= cfg.image_height) begin
            row_cur    = 14'd0;
            parity_cur = 1'b0;
          end
          row_next    = row_cur;
          parity_next = ~parity_cur;
          column_next = 17'd0;
          if (cfg.row_stride <= STRIDE_SHORT_MAX) begin
            row_bytes_left_next = {8'h00, in_byte};
            if (in_byte == 8'd0) row_end = 1'b1;
            else phase_next = PH_HEADER;
          end else begin
            count_high_next = in_byte;
            phase_next      = PH_COUNT_LOW;
          end
        end
      end
      PH_COUNT_LOW: begin
        parity_next         = ~parity;
        column_next         = 17'd0;
        row_bytes_left_next = {count_high, in_byte};
        if ({count_high, in_byte} == 16'd0) row_end = 1'b1;
        else phase_next = PH_HEADER;
      end
      PH_HEADER: begin
        parity_next         = ~parity;
        row_bytes_left_next = rbl_dec;
        if (in_byte[7]) begin
          repeat_count_next = 8'(REPEAT_BASE - {1'b0, in_byte});
          phase_next        = PH_REPEAT;
        end else begin
          literal_left_next = in_byte + 8'd1;
          phase_next        = PH_LITERAL;
        end
        row_end = (rbl_dec == 16'd0);
      end
      PH_REPEAT: begin
        parity_next         = ~parity;
        row_bytes_left_next = rbl_dec;
        emit                = 1'b1;
        len                 = repeat_count;
        phase_next          = PH_HEADER;
        row_end             = (rbl_dec == 16'd0);
      end
      PH_LITERAL: begin
        parity_next         = ~parity;
        row_bytes_left_next = rbl_dec;
        emit                = 1'b1;
        len                 = 8'd1;
        literal_left_next   = lit_dec;
        if (lit_dec == 8'd0) phase_next = PH_HEADER;
        row_end = (rbl_dec == 16'd0);
      end
      PH_PAD: begin
        phase_next  = PH_COUNT;
        row_next    = 14'd0;
        parity_next = 1'b0;
      end
      default: begin
        phase_next = PH_COUNT;
      end
    endcase

    if (emit) begin
      col_sum     = {1'b0, column} + {10'd0, len};
      column_next = col_sum[17] ? COLUMN_MAX : col_sum[16:0];
    end else begin
      col_sum = 18'd0;
    end

    if (row_end) begin
      phase_next        = PH_COUNT;
      column_next       = 17'd0;
      literal_left_next = 8'd0;
      repeat_count_next = 8'd0;
      row_inc           = {1'b0, row_cur} + 15'd1;
      if (row_inc >= {1'b0, cfg.image_height}) begin
        done = 1'b1;
        if (parity_next) begin
          phase_next = PH_PAD;
          row_next   = row_inc[13:0];
        end else begin
          row_next    = 14'd0;
          parity_next = 1'b0;
        end
      end else begin
        row_next = row_inc[13:0];
      end
    end
  end

  // visible part of the run, clipped to the image width
  assign vis    = emit && ({3'd0, cfg.image_width} > column);
  assign room17 = {3'd0, cfg.image_width} - column;
  assign room   = room17[13:0];
  assign rl     = ({6'd0, len} < room) ? len : room[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_COUNT;
      row_bytes_left <= 16'd0;
      literal_left   <= 8'd0;
      repeat_count   <= 8'd0;
      count_high     <= 8'd0;
      column         <= 17'd0;
      row            <= 14'd0;
      parity         <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      row_bytes_left <= row_bytes_left_next;
      literal_left   <= literal_left_next;
      repeat_count   <= repeat_count_next;
      count_high     <= count_high_next;
      column         <= column_next;
      row            <= row_next;
      parity         <= parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vis;
    end else if (runs.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vis) begin
      out_index  <= in_byte;
      out_column <= column[15:0] + cfg.origin_left;
      out_row    <= {2'b00, row_cur} + cfg.origin_top;
      out_len    <= rl;
      out_done   <= done;
    end
  end

  assign runs.valid        = out_valid;
  assign runs.pixel_index  = out_index;
  assign runs.pixel_column = $signed(out_column);
  assign runs.pixel_row    = $signed(out_row);
  assign runs.run_length   = out_len;
  assign runs.image_done   = out_done;

endmodule

FILE: hdl/packbits_indexed_pixel_decoder.sv
// channel   dir  payload                                              beat when
// stream    in   stream_byte[7:0]                                     valid && ready
// runs      out  pixel_index, pixel_column, pixel_row, run_length,    valid && ready
//                image_done
// cfg       in   cfg_index[2:0], cfg_data[15:0]                        cfg_we
//
// One byte per cycle while runs is ready; a run is registered in the result register
// as its byte leaves the input register. Latency is set by these two around the decoder.
// rst is synchronous: phase returns to row count, counters and config clear.
// A stall on runs holds the result register; one more byte waits in the input
// register, then stream ready drops until the result register drains.
module packbits_indexed_pixel_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  pbd_byte_if.sink                        stream,
  pbd_run_if.source                       runs
);
  import pbd_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_STRIDE:   cfg.row_stride   <= cfg_data[13:0];
        CFG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[13:0];
        CFG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[13:0];
        CFG_ORIGIN_LEFT:  cfg.origin_left  <= $signed(cfg_data);
        CFG_ORIGIN_TOP:   cfg.origin_top   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  pbd_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream),
    .advance (advance),
    .valid   (s1_valid),
    .data    (s1_byte)
  );

  pbd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_byte  (s1_byte),
    .advance  (advance),
    .cfg      (cfg),
    .runs     (runs)
  );

endmodule
